// ===== sv/gpps_pkg.sv =====
// ----------------------------------------------------------------------------
// gpps_pkg
// Shared types for the prime pair search: controller states and the command
// and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gpps_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_TSTART,
        ST_TCHECK,
        ST_DIV,
        ST_DIVEND,
        ST_NEXT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic setup_large;
        logic test_start;
        logic div_start;
        logic div_step;
        logic d_next;
        logic cand_next;
        logic set_result;
        logic result_hit;
        logic out_load;
    } gpps_cmd_t;

    typedef struct packed {
        logic half_lt2;
        logic odd;
        logic n_lt2;
        logic sq_gt_n;
        logic div_last;
        logic rem_zero;
        logic cand_gt_half;
        logic phase_large;
    } gpps_sts_t;

endpackage

// ===== sv/gpps_datapath.sv =====
// ----------------------------------------------------------------------------
// gpps_datapath
// Holds the target, candidate and trial divisor, the bit-serial remainder
// unit and the result register.
// ----------------------------------------------------------------------------
module gpps_datapath #(
    parameter int VALUE_BITS = 31
) (
    input  logic                    aclk,
    input  gpps_pkg::gpps_cmd_t     cmd,
    output gpps_pkg::gpps_sts_t     sts,
    input  logic [VALUE_BITS-1:0]   s_target_value,
    output logic                    m_found,
    output logic [VALUE_BITS-2:0]   m_smaller_prime,
    output logic [VALUE_BITS-1:0]   m_larger_prime
);
    import gpps_pkg::*;

    localparam int DW = VALUE_BITS / 2 + 2;
    localparam int SW = VALUE_BITS + 2;
    localparam int CW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] m_reg;
    logic [VALUE_BITS-1:0] cand_reg;
    logic                  phase_large_reg;
    logic [VALUE_BITS-1:0] n_reg;
    logic [DW-1:0]         d_reg;
    logic [SW-1:0]         sq_reg;
    logic [DW-1:0]         rem_reg;
    logic [CW-1:0]         bit_cnt_reg;
    logic                  hit_reg;
    logic                  found_reg;
    logic [VALUE_BITS-2:0] small_reg;
    logic [VALUE_BITS-1:0] large_reg;

    logic [VALUE_BITS-1:0] half;
    logic [VALUE_BITS-1:0] diff;
    logic [VALUE_BITS-1:0] n_sel;
    logic [DW:0]           div_trial;
    logic [DW:0]           div_sub;
    logic                  div_ge;
    logic [SW-1:0]         sq_next;

    always_comb begin
        half      = {1'b0, m_reg[VALUE_BITS-1:1]};
        diff      = m_reg - cand_reg;
        n_sel     = phase_large_reg ? diff : cand_reg;
        div_trial = {rem_reg, n_reg[bit_cnt_reg]};
        div_sub   = div_trial - {1'b0, d_reg};
        div_ge    = div_trial >= {1'b0, d_reg};
        // (d+1)^2 = d^2 + 2d + 1
        sq_next   = sq_reg + SW'({d_reg, 1'b0}) + SW'(1);
    end

    always_comb begin
        sts.half_lt2     = half < VALUE_BITS'(2);
        sts.odd          = m_reg[0];
        sts.n_lt2        = n_reg < VALUE_BITS'(2);
        sts.sq_gt_n      = sq_reg > {2'b00, n_reg};
        sts.div_last     = bit_cnt_reg == '0;
        sts.rem_zero     = rem_reg == '0;
        sts.cand_gt_half = cand_reg > half;
        sts.phase_large  = phase_large_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg           <= s_target_value;
            cand_reg        <= VALUE_BITS'(2);
            phase_large_reg <= 1'b0;
        end
        if (cmd.setup_large) begin
            phase_large_reg <= 1'b1;
        end
        if (cmd.test_start) begin
            n_reg  <= n_sel;
            d_reg  <= DW'(2);
            sq_reg <= SW'(4);
        end
        if (cmd.div_start) begin
            rem_reg     <= '0;
            bit_cnt_reg <= CW'(VALUE_BITS - 1);
        end
        if (cmd.div_step) begin
            // restoring step, one dividend bit a cycle
            rem_reg     <= div_ge ? div_sub[DW-1:0] : div_trial[DW-1:0];
            bit_cnt_reg <= bit_cnt_reg - CW'(1);
        end
        if (cmd.d_next) begin
            d_reg  <= d_reg + DW'(1);
            sq_reg <= sq_next;
        end
        if (cmd.cand_next) begin
            cand_reg        <= cand_reg + VALUE_BITS'(1);
            phase_large_reg <= 1'b0;
        end
        if (cmd.set_result) begin
            hit_reg <= cmd.result_hit;
        end
        if (cmd.out_load) begin
            found_reg <= hit_reg;
            small_reg <= hit_reg ? cand_reg[VALUE_BITS-2:0] : '0;
            large_reg <= hit_reg ? diff : '0;
        end
    end

    assign m_found         = found_reg;
    assign m_smaller_prime = small_reg;
    assign m_larger_prime  = large_reg;

endmodule

// ===== sv/gpps_controller.sv =====
// ----------------------------------------------------------------------------
// gpps_controller
// Sequences the search: candidate walk, primality tests by trial division,
// remainder iterations and the result handshake.
// ----------------------------------------------------------------------------
module gpps_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  gpps_pkg::gpps_sts_t  sts,
    output gpps_pkg::gpps_cmd_t  cmd
);
    import gpps_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        verdict;
    logic        verdict_prime;
    logic        out_free;

    // a test ends with a verdict on n below two, on the square bound or on a zero remainder
    always_comb begin
        verdict       = 1'b0;
        verdict_prime = 1'b0;
        if (state_reg == ST_TCHECK) begin
            verdict       = sts.n_lt2 || sts.sq_gt_n;
            verdict_prime = !sts.n_lt2;
        end else if (state_reg == ST_DIVEND) begin
            verdict       = sts.rem_zero;
            verdict_prime = 1'b0;
        end
        out_free = !out_valid_reg || m_ready;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                if (sts.half_lt2) state_next = ST_DONE;
                else              state_next = ST_TSTART;
            end
            ST_TSTART: begin
                state_next = ST_TCHECK;
            end
            ST_TCHECK, ST_DIVEND: begin
                if (verdict) begin
                    if (verdict_prime) begin
                        state_next = sts.phase_large ? ST_DONE : ST_TSTART;
                    end else begin
                        state_next = sts.odd ? ST_DONE : ST_NEXT;
                    end
                end else if (state_reg == ST_TCHECK) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_TCHECK;
                end
            end
            ST_DIV: begin
                if (sts.div_last) state_next = ST_DIVEND;
            end
            ST_NEXT: begin
                state_next = sts.cand_gt_half ? ST_DONE : ST_TSTART;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SETUP: begin
                if (sts.half_lt2) begin
                    cmd.set_result = 1'b1;
                end else if (sts.odd) begin
                    // odd target: only the pair (2, m-2) can work
                    cmd.setup_large = 1'b1;
                end
            end
            ST_TSTART: begin
                cmd.test_start = 1'b1;
            end
            ST_TCHECK, ST_DIVEND: begin
                if (verdict) begin
                    if (verdict_prime && !sts.phase_large) begin
                        cmd.setup_large = 1'b1;
                    end else if (verdict_prime) begin
                        cmd.set_result = 1'b1;
                        cmd.result_hit = 1'b1;
                    end else if (sts.odd) begin
                        cmd.set_result = 1'b1;
                    end else begin
                        cmd.cand_next = 1'b1;
                    end
                end else if (state_reg == ST_TCHECK) begin
                    cmd.div_start = 1'b1;
                end else begin
                    cmd.d_next = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_NEXT: begin
                cmd.set_result = sts.cand_gt_half;
            end
            ST_DONE: begin
                cmd.out_load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load)     out_valid_next = 1'b1;
        else if (m_ready)     out_valid_next = 1'b0;
        else                  out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== sv/goldbach_prime_pair_search_unit.sv =====
// sequence: a target below four goes from setup straight to the output load; otherwise
//   setup is followed by primality tests, one remainder pass per trial divisor and a
//   candidate step per rejected candidate; a test of n uses up to sqrt(n) divisors
// throughput: one item at a time, set by the single bit-serial remainder unit; the next
//   transaction is taken from the cycle after the result enters the output register
// reset: synchronous active-low aresetn returns the controller to idle, output empty
// ----------------------------------------------------------------------------
// goldbach_prime_pair_search_unit
// Finds the smallest prime pair (p, m-p) summing to the target, by walking
// candidates and testing each value with trial division.
// ----------------------------------------------------------------------------
module goldbach_prime_pair_search_unit #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_target_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [VALUE_BITS-2:0] m_smaller_prime,
    output logic [VALUE_BITS-1:0] m_larger_prime
);
    import gpps_pkg::*;

    gpps_cmd_t cmd;
    gpps_sts_t sts;

    gpps_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gpps_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk            (aclk),
        .cmd             (cmd),
        .sts             (sts),
        .s_target_value  (s_target_value),
        .m_found         (m_found),
        .m_smaller_prime (m_smaller_prime),
        .m_larger_prime  (m_larger_prime)
    );

endmodule

// ===== sv/gpps_checker.sv =====
// ----------------------------------------------------------------------------
// gpps_checker
// Port-level checks on the result channel of the prime pair search unit.
// ----------------------------------------------------------------------------
module gpps_checker #(
    parameter int VALUE_BITS = 31
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_found,
    input logic [VALUE_BITS-2:0] m_smaller_prime,
    input logic [VALUE_BITS-1:0] m_larger_prime
);

    // a stalled result transaction stays offered
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_found) && $stable(m_smaller_prime)
                                && $stable(m_larger_prime))
        else $error("result payload changed while stalled");

    // no pair means both primes read zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_smaller_prime == '0 && m_larger_prime == '0)
        else $error("primes not zero on a miss");

    // a found pair is ordered and its smaller member is at least two
    a_hit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_smaller_prime >= (VALUE_BITS-1)'(2)
                               && {1'b0, m_smaller_prime} <= m_larger_prime)
        else $error("found pair out of order");

endmodule

bind goldbach_prime_pair_search_unit gpps_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_gpps_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_found         (m_found),
    .m_smaller_prime (m_smaller_prime),
    .m_larger_prime  (m_larger_prime)
);
